// ===== rtl/mss_pkg.sv =====
package mss_pkg;

    // default sizing
    localparam int MAX_PATTERN_DEF = 16;
    localparam int OFFSET_BITS_DEF = 32;

    // fixed register and field widths
    localparam int CFG_DATA_W      = 64;
    localparam int CFG_INDEX_W     = 3;
    localparam int LENGTH_W        = 5;
    localparam int START_W         = 32;
    localparam int RESULT_OFFSET_W = 32;
    localparam int CODE_W          = 4;
    localparam int BYTE_W          = 8;

    // mask codes
    localparam logic [CODE_W-1:0] CODE_WILD       = 4'd0;
    localparam logic [CODE_W-1:0] CODE_EXACT      = 4'd1;
    localparam logic [CODE_W-1:0] CODE_GROUP_LAST = 4'd11;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PATTERN_LOW    = 3'd0,
        REG_PATTERN_HIGH   = 3'd1,
        REG_MASK_CODES     = 3'd2,
        REG_PATTERN_LENGTH = 3'd3,
        REG_START_OFFSET   = 3'd4
    } cfg_reg_t;

    // result status codes
    typedef enum logic [1:0] {
        STATUS_MATCH     = 2'd0,
        STATUS_NOT_FOUND = 2'd1,
        STATUS_INVALID   = 2'd2
    } scan_status_t;

    // configuration as seen by the datapath
    typedef struct packed {
        logic [2*CFG_DATA_W-1:0] pattern_bytes;
        logic [CFG_DATA_W-1:0]   mask_codes;
        logic [LENGTH_W-1:0]     eff_length;
        logic [START_W-1:0]      start_offset;
    } cfg_t;

endpackage

// ===== rtl/masked_signature_scanner.sv =====
// Masked byte signature scanner. A memory region streams in one byte per beat, last_byte
// set on its final byte, and every alignment at or after start_offset is compared against
// a pattern of up to MAX_PATTERN positions (wildcard, exact byte, or one of ten groups
// whose bytes must agree). Each region yields exactly one result beat: match with the
// offset just past the first hit, nothing found at the region end, or invalid when an
// alignment matches up to an invalid mask code. Throughput is one byte per clock while
// the input is not stalled: the whole window is compared in parallel in the single stage
// between the input and result registers, so a result is registered as its byte leaves
// the input register. Input is stalled only while a finished result is held by a stalled
// output. Write the configuration registers only while no region is in flight.
module masked_signature_scanner
    import mss_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write_en,
    input  logic [CFG_INDEX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [BYTE_W-1:0]          data_byte,
    input  logic                       last_byte,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [1:0]                 scan_status,
    output logic [RESULT_OFFSET_W-1:0] match_end_offset
);

    localparam int CMP_W = ((OFFSET_BITS > START_W) ? OFFSET_BITS : START_W) + 1;
    localparam logic [OFFSET_BITS-1:0] COUNT_FULL = '1;

    cfg_t cfg;

    logic                               in_valid_reg;
    logic [BYTE_W-1:0]                  data_reg;
    logic                               last_reg;
    logic [MAX_PATTERN-1:0][BYTE_W-1:0] window_reg;
    logic [MAX_PATTERN-1:0][BYTE_W-1:0] window_next;
    logic [MAX_PATTERN-1:0][BYTE_W-1:0] shifted;
    logic [OFFSET_BITS-1:0]             bytes_seen_reg;
    logic [OFFSET_BITS-1:0]             bytes_seen_next;
    logic [OFFSET_BITS-1:0]             seen_inc;
    logic                               region_done_reg;
    logic                               region_done_next;
    logic                               out_valid_reg;
    logic                               out_valid_next;
    scan_status_t                       status_reg;
    scan_status_t                       status_next;
    logic [RESULT_OFFSET_W-1:0]         offset_reg;
    logic [RESULT_OFFSET_W-1:0]         offset_next;
    logic                               advance;
    logic                               live;
    logic                               test_en;
    logic [CMP_W-1:0]                   threshold;
    scan_status_t                       test_status;

    mss_cfg_regs #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_cfg_regs (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cfg          (cfg)
    );

    // handshake: the stored beat moves on when the result slot is free
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (!in_stall)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            data_reg <= data_byte;
            last_reg <= last_byte;
        end
    end

    // window with the stored byte shifted in
    always_comb
    begin
        shifted[0] = data_reg;
        for (int i = 1; i < MAX_PATTERN; i++)
            shifted[i] = window_reg[i-1];
    end

    mss_matcher #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_matcher (
        .window (shifted),
        .cfg    (cfg),
        .status (test_status)
    );

    // alignment ending at this byte is tested once it starts at or after start_offset
    assign seen_inc  = bytes_seen_reg + OFFSET_BITS'(1);
    assign threshold = CMP_W'(cfg.start_offset) + CMP_W'(cfg.eff_length) - CMP_W'(1);
    assign test_en   = CMP_W'(bytes_seen_reg) >= threshold;
    assign live      = !region_done_reg && (bytes_seen_reg != COUNT_FULL);

    // region state and result slot
    always_comb
    begin
        window_next      = window_reg;
        bytes_seen_next  = bytes_seen_reg;
        region_done_next = region_done_reg;
        out_valid_next   = out_valid_reg;
        status_next      = status_reg;
        offset_next      = offset_reg;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        if (advance)
        begin
            if (live)
            begin
                window_next     = shifted;
                bytes_seen_next = seen_inc;
                if (test_en && (test_status != STATUS_NOT_FOUND))
                begin
                    out_valid_next   = 1'b1;
                    status_next      = test_status;
                    offset_next      = (test_status == STATUS_MATCH)
                                       ? RESULT_OFFSET_W'(seen_inc) : '0;
                    region_done_next = 1'b1;
                end
            end
            if (last_reg)
            begin
                if (!region_done_next)
                begin
                    out_valid_next = 1'b1;
                    status_next    = STATUS_NOT_FOUND;
                    offset_next    = '0;
                end
                window_next      = '0;
                bytes_seen_next  = '0;
                region_done_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg      <= '0;
            bytes_seen_reg  <= '0;
            region_done_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            window_reg      <= window_next;
            bytes_seen_reg  <= bytes_seen_next;
            region_done_reg <= region_done_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        offset_reg <= offset_next;
    end

    assign out_valid        = out_valid_reg;
    assign scan_status      = status_reg;
    assign match_end_offset = offset_reg;

endmodule

// ===== rtl/mss_cfg_regs.sv =====
module mss_cfg_regs
    import mss_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                   cfg
);

    logic [CFG_DATA_W-1:0] pattern_low_reg;
    logic [CFG_DATA_W-1:0] pattern_high_reg;
    logic [CFG_DATA_W-1:0] mask_codes_reg;
    logic [LENGTH_W-1:0]   length_reg;
    logic [START_W-1:0]    start_offset_reg;
    logic [LENGTH_W-1:0]   eff_length;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg  <= '0;
            pattern_high_reg <= '0;
            mask_codes_reg   <= '0;
            length_reg       <= LENGTH_W'(1);
            start_offset_reg <= '0;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                REG_PATTERN_LOW:    pattern_low_reg  <= cfg_data;
                REG_PATTERN_HIGH:   pattern_high_reg <= cfg_data;
                REG_MASK_CODES:     mask_codes_reg   <= cfg_data;
                REG_PATTERN_LENGTH: length_reg       <= cfg_data[LENGTH_W-1:0];
                REG_START_OFFSET:   start_offset_reg <= cfg_data[START_W-1:0];
                default:            ;
            endcase
        end
    end

    // clamp length into 1..MAX_PATTERN
    always_comb
    begin
        priority if (length_reg == '0)
            eff_length = LENGTH_W'(1);
        else if (length_reg > LENGTH_W'(MAX_PATTERN))
            eff_length = LENGTH_W'(MAX_PATTERN);
        else
            eff_length = length_reg;
    end

    assign cfg.pattern_bytes = {pattern_high_reg, pattern_low_reg};
    assign cfg.mask_codes    = mask_codes_reg;
    assign cfg.eff_length    = eff_length;
    assign cfg.start_offset  = start_offset_reg;

endmodule

// ===== rtl/mss_matcher.sv =====
module mss_matcher
    import mss_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
)
(
    input  logic [MAX_PATTERN-1:0][BYTE_W-1:0] window,
    input  cfg_t                               cfg,
    output scan_status_t                       status
);

    localparam int SUM_W = LENGTH_W + 1;

    logic [MAX_PATTERN-1:0][CODE_W-1:0] code;
    logic [MAX_PATTERN-1:0][BYTE_W-1:0] pos_byte;
    logic [MAX_PATTERN-1:0][BYTE_W-1:0] pat_byte;
    logic [MAX_PATTERN-1:0]             in_use;
    logic [MAX_PATTERN-1:0]             bad;
    logic [MAX_PATTERN-1:0]             checked;
    logic [MAX_PATTERN-1:0]             holds;
    logic                               fail;

    // per position: code, pattern byte, aligned window byte
    always_comb
    begin
        for (int p = 0; p < MAX_PATTERN; p++)
        begin
            code[p]     = cfg.mask_codes[CODE_W*p +: CODE_W];
            pat_byte[p] = cfg.pattern_bytes[BYTE_W*p +: BYTE_W];
            in_use[p]   = LENGTH_W'(p) < cfg.eff_length;
            bad[p]      = in_use[p] && (code[p] > CODE_GROUP_LAST);
            // position p sits eff_length-1-p places behind the newest byte
            pos_byte[p] = '0;
            for (int j = 0; j < MAX_PATTERN; j++)
            begin
                if (SUM_W'(j) + SUM_W'(p) + SUM_W'(1) == SUM_W'(cfg.eff_length))
                    pos_byte[p] = window[j];
            end
        end
    end

    // only positions ahead of the first invalid code are checked; group tests still compare every member in use
    always_comb
    begin
        logic seen_bad;
        seen_bad = 1'b0;
        for (int p = 0; p < MAX_PATTERN; p++)
        begin
            seen_bad   = seen_bad | bad[p];
            checked[p] = in_use[p] && !seen_bad;
        end
    end

    // position tests: wildcard, exact byte, or group equality
    always_comb
    begin
        for (int p = 0; p < MAX_PATTERN; p++)
        begin
            priority if (code[p] == CODE_WILD)
                holds[p] = 1'b1;
            else if (code[p] == CODE_EXACT)
                holds[p] = (pos_byte[p] == pat_byte[p]);
            else
            begin
                holds[p] = 1'b1;
                for (int q = 0; q < MAX_PATTERN; q++)
                begin
                    if (in_use[q] && (code[q] == code[p]) && (pos_byte[q] != pos_byte[p]))
                        holds[p] = 1'b0;
                end
            end
        end
    end

    assign fail = |(checked & ~holds);

    // alignment verdict
    always_comb
    begin
        priority if (fail)
            status = STATUS_NOT_FOUND;
        else if (|bad)
            status = STATUS_INVALID;
        else
            status = STATUS_MATCH;
    end

endmodule

// ===== rtl/mss_checker.sv =====
module mss_checker
    import mss_pkg::*;
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_stall,
    input logic                       out_valid,
    input logic                       out_stall,
    input logic [1:0]                 scan_status,
    input logic [RESULT_OFFSET_W-1:0] match_end_offset
);

    // a held result beat stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(scan_status)
                                   && $stable(match_end_offset))
        else $error("result beat changed while stalled");

    // only defined status codes leave the block
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (scan_status == STATUS_MATCH) || (scan_status == STATUS_NOT_FOUND)
                      || (scan_status == STATUS_INVALID))
        else $error("undefined scan status");

    // offset is zero unless a match is reported
    a_offset_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (scan_status != STATUS_MATCH) |-> match_end_offset == '0)
        else $error("nonzero offset without a match");

    // input only backs up behind a stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled with free result slot");

endmodule

bind masked_signature_scanner mss_checker u_mss_checker (.*);

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import mss_pkg::*;

    localparam int QUIET_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 200;
    localparam int RANDOM_BYTES  = 1600;
    localparam int PHASE_BYTES   = 115;
    localparam int SETTLE_CYCLES = 6;

    localparam logic [CODE_W-1:0] CODE_GROUP_FIRST   = CODE_EXACT + 1'b1;
    localparam logic [CODE_W-1:0] CODE_INVALID_FIRST = CODE_GROUP_LAST + 1'b1;
    localparam logic [CODE_W-1:0] CODE_INVALID_LAST  = '1;

    typedef struct {
        scan_status_t                 status;
        logic [RESULT_OFFSET_W-1:0]   offset;
    } scan_verdict_t;

    // mirror of the scanner: window, byte count and the verdicts still owed
    class signature_scoreboard;
        logic [CFG_DATA_W-1:0]      pattern_low;
        logic [CFG_DATA_W-1:0]      pattern_high;
        logic [CFG_DATA_W-1:0]      codes;
        logic [LENGTH_W-1:0]        length_reg;
        logic [START_W-1:0]         start;
        logic [BYTE_W-1:0]          window [MAX_PATTERN_DEF];
        logic [OFFSET_BITS_DEF-1:0] seen;
        bit                         done;
        scan_verdict_t              pending_verdicts [$];
        int                         errors;
        int                         bytes_taken;

        function new();
            pattern_low  = '0;
            pattern_high = '0;
            codes        = '0;
            length_reg   = LENGTH_W'(1);
            start        = '0;
            foreach (window[i]) window[i] = '0;
            seen        = '0;
            done        = 1'b0;
            errors      = 0;
            bytes_taken = 0;
        endfunction

        function void set_register(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_PATTERN_LOW:    pattern_low  = value;
                REG_PATTERN_HIGH:   pattern_high = value;
                REG_MASK_CODES:     codes        = value;
                REG_PATTERN_LENGTH: length_reg   = value[LENGTH_W-1:0];
                REG_START_OFFSET:   start        = value[START_W-1:0];
                default: ;
            endcase
        endfunction

        // length clamped into 1..MAX_PATTERN
        function int eff_len();
            if (length_reg == '0)
                return 1;
            if (int'(length_reg) > MAX_PATTERN_DEF)
                return MAX_PATTERN_DEF;
            return int'(length_reg);
        endfunction

        function logic [CODE_W-1:0] code_of(int p);
            return codes[p*CODE_W +: CODE_W];
        endfunction

        function logic [BYTE_W-1:0] pattern_of(int p);
            logic [2*CFG_DATA_W-1:0] both;
            both = {pattern_high, pattern_low};
            return both[p*BYTE_W +: BYTE_W];
        endfunction

        // newest full window: match, miss (not found) or invalid code reached
        function scan_status_t judge_window(int len);
            int                  stop;
            int                  p;
            int                  q;
            logic [CODE_W-1:0]   c;
            logic [BYTE_W-1:0]   b;
            stop = len;
            for (p = len - 1; p >= 0; p--)
                if (code_of(p) > CODE_GROUP_LAST)
                    stop = p;
            for (p = 0; p < stop; p++)
            begin
                c = code_of(p);
                b = window[len-1-p];
                if (c == CODE_EXACT)
                begin
                    if (b != pattern_of(p))
                        return STATUS_NOT_FOUND;
                end
                else if (c != CODE_WILD)
                begin
                    // every member of the group in use, later ones too
                    for (q = 0; q < len; q++)
                        if (code_of(q) == c && window[len-1-q] != b)
                            return STATUS_NOT_FOUND;
                end
            end
            if (stop < len)
                return STATUS_INVALID;
            return STATUS_MATCH;
        endfunction

        function void take_byte(logic [BYTE_W-1:0] d, logic last);
            int            len;
            int            i;
            logic [63:0]   off;
            scan_status_t  verdict;
            scan_verdict_t v;
            bytes_taken++;
            if (!done && seen != '1)
            begin
                len = eff_len();
                off = 64'(seen);
                for (i = MAX_PATTERN_DEF - 1; i > 0; i--)
                    window[i] = window[i-1];
                window[0] = d;
                seen = seen + 1'b1;
                if (off + 64'd1 >= 64'(len) && off + 64'd1 - 64'(len) >= 64'(start))
                begin
                    verdict = judge_window(len);
                    if (verdict == STATUS_MATCH)
                    begin
                        v.status = STATUS_MATCH;
                        v.offset = RESULT_OFFSET_W'(off + 64'd1);
                        pending_verdicts.push_back(v);
                        done = 1'b1;
                    end
                    else if (verdict == STATUS_INVALID)
                    begin
                        v.status = STATUS_INVALID;
                        v.offset = '0;
                        pending_verdicts.push_back(v);
                        done = 1'b1;
                    end
                end
            end
            // region end: not found unless already decided, then start afresh
            if (last)
            begin
                if (!done)
                begin
                    v.status = STATUS_NOT_FOUND;
                    v.offset = '0;
                    pending_verdicts.push_back(v);
                end
                foreach (window[k]) window[k] = '0;
                seen = '0;
                done = 1'b0;
            end
        endfunction

        function void check_verdict(logic [1:0] status, logic [RESULT_OFFSET_W-1:0] offset);
            scan_verdict_t want;
            if (pending_verdicts.size() == 0)
            begin
                $display("%0t ns: result beat with none expected: status %0d offset %0d",
                         $time, status, offset);
                errors++;
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (status !== want.status)
                begin
                    $display("%0t ns: scan_status expected %0d actual %0d",
                             $time, want.status, status);
                    errors++;
                end
                if (offset !== want.offset)
                begin
                    $display("%0t ns: match_end_offset expected %0d actual %0d",
                             $time, want.offset, offset);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_write_en;
    logic [CFG_INDEX_W-1:0]     cfg_index;
    logic [CFG_DATA_W-1:0]      cfg_data;
    logic                       in_valid;
    logic                       in_stall;
    logic [BYTE_W-1:0]          data_byte;
    logic                       last_byte;
    logic                       out_valid;
    logic                       out_stall;
    logic [1:0]                 scan_status;
    logic [RESULT_OFFSET_W-1:0] match_end_offset;

    signature_scoreboard sb;
    logic [BYTE_W-1:0]   region_bytes [$];
    int                  send_idle_pct = 15;
    int                  recv_stall_pct = 77;
    bit                  hold_armed = 1'b0;
    int                  hold_cycles = 0;
    int                  quiet_cycles = 0;
    int                  phase_no = 0;

    masked_signature_scanner DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_en     (cfg_write_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .data_byte        (data_byte),
        .last_byte        (last_byte),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .scan_status      (scan_status),
        .match_end_offset (match_end_offset)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // beat monitor and quiet-cycle count
    always @(posedge clk)
    begin
        if (in_valid && !in_stall)
            sb.take_byte(data_byte, last_byte);
        if (out_valid && !out_stall)
            sb.check_verdict(scan_status, match_end_offset);
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // watchdog
    initial
    begin
        @(posedge clk);
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("%0t ns: no beat accepted for %0d cycles", $time, QUIET_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    // result side: random stall, one long hold-off once armed
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_armed && hold_cycles < HOLD_CYCLES)
            begin
                hold_cycles++;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
            end
        end
    end

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= value;
        sb.set_register(idx, value);
        @(posedge clk);
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] lo, input logic [CFG_DATA_W-1:0] hi,
                             input logic [CFG_DATA_W-1:0] codes,
                             input logic [LENGTH_W-1:0] len, input logic [START_W-1:0] start);
        write_reg(REG_PATTERN_LOW, lo);
        write_reg(REG_PATTERN_HIGH, hi);
        write_reg(REG_MASK_CODES, codes);
        write_reg(REG_PATTERN_LENGTH, CFG_DATA_W'(len));
        write_reg(REG_START_OFFSET, CFG_DATA_W'(start));
        cfg_write_en <= 1'b0;
    endtask

    // one input beat, with random idle cycles ahead of it
    task automatic send_byte(input logic [BYTE_W-1:0] d, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= d;
        last_byte <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic send_region();
        int i;
        for (i = 0; i < region_bytes.size(); i++)
            send_byte(region_bytes[i], i == region_bytes.size() - 1);
    endtask

    // stop offering and let every owed result come out
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // one random setting followed by a run of regions
    task automatic random_phase();
        logic [CFG_DATA_W-1:0]   lo;
        logic [CFG_DATA_W-1:0]   hi;
        logic [CFG_DATA_W-1:0]   codes;
        logic [2*CFG_DATA_W-1:0] both;
        logic [LENGTH_W-1:0]     len_sel;
        logic [START_W-1:0]      start_sel;
        logic [BYTE_W-1:0]       group_val [16];
        logic [CODE_W-1:0]       grp_a;
        logic [CODE_W-1:0]       grp_b;
        logic [CODE_W-1:0]       c;
        int                      invalid_pct;
        int                      elen;
        int                      region_len;
        int                      at;
        int                      p;
        int                      r;
        int                      phase_bytes;
        bit                      narrow;

        lo = {$urandom, $urandom};
        hi = {$urandom, $urandom};
        both = {hi, lo};
        case (phase_no % 8)
            0: len_sel = LENGTH_W'(1);
            1: len_sel = LENGTH_W'(MAX_PATTERN_DEF);
            2: len_sel = '1;
            3: len_sel = '0;
            4: len_sel = LENGTH_W'(MAX_PATTERN_DEF + 1);
            default: len_sel = LENGTH_W'($urandom_range(2, 8));
        endcase
        case (phase_no % 7)
            0: start_sel = '0;
            5: start_sel = '1;
            6: start_sel = $urandom;
            default: start_sel = START_W'($urandom_range(0, 10));
        endcase
        invalid_pct = (phase_no % 4 == 2) ? 6 : 0;
        grp_a = CODE_W'($urandom_range(CODE_GROUP_FIRST, CODE_GROUP_LAST));
        grp_b = CODE_W'($urandom_range(CODE_GROUP_FIRST, CODE_GROUP_LAST));
        for (p = 0; p < MAX_PATTERN_DEF; p++)
        begin
            r = $urandom_range(0, 99);
            if (r < invalid_pct)
                c = CODE_W'($urandom_range(CODE_INVALID_FIRST, CODE_INVALID_LAST));
            else if (r < 40)
                c = CODE_WILD;
            else if (r < 70)
                c = CODE_EXACT;
            else if (r < 85)
                c = grp_a;
            else
                c = grp_b;
            codes[p*CODE_W +: CODE_W] = c;
        end
        configure(lo, hi, codes, len_sel, start_sel);
        elen = sb.eff_len();

        phase_bytes = 0;
        while (phase_bytes < PHASE_BYTES)
        begin
            if ($urandom_range(0, 99) < 80)
                region_len = $urandom_range(1, elen + 12);
            else
                region_len = $urandom_range(elen + 13, 70);
            region_bytes.delete();
            narrow = ($urandom_range(0, 3) == 0);
            for (p = 0; p < region_len; p++)
                region_bytes.push_back(narrow ? BYTE_W'($urandom_range(0, 3)) : BYTE_W'($urandom));
            // plant a matching instance in most regions
            if (region_len >= elen && $urandom_range(0, 99) < 70)
            begin
                foreach (group_val[g]) group_val[g] = BYTE_W'($urandom);
                at = $urandom_range(0, region_len - elen);
                for (p = 0; p < elen; p++)
                begin
                    c = codes[p*CODE_W +: CODE_W];
                    if (c == CODE_EXACT)
                        region_bytes[at+p] = both[p*BYTE_W +: BYTE_W];
                    else if (c >= CODE_GROUP_FIRST && c <= CODE_GROUP_LAST)
                        region_bytes[at+p] = group_val[c];
                end
            end
            send_region();
            phase_bytes += region_len;
        end
    endtask

    initial
    begin
        logic [CFG_DATA_W-1:0] dir_codes;
        int                    first_taken;

        sb = new();
        rst_n        <= 1'b0;
        cfg_write_en <= 1'b0;
        cfg_index    <= REG_PATTERN_LOW;
        cfg_data     <= '0;
        in_valid     <= 1'b0;
        data_byte    <= '0;
        last_byte    <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset setting: single wildcard, then a byte ignored after the match
        region_bytes = '{8'h00, 8'hFF};
        send_region();
        wait_idle();

        // exact byte plus a two-member group, match on the last byte and a group miss
        dir_codes = '0;
        dir_codes[3:0]  = CODE_EXACT;
        dir_codes[7:4]  = CODE_GROUP_FIRST;
        dir_codes[11:8] = CODE_GROUP_FIRST;
        configure(64'h0000_0000_0000_00FF, '1, dir_codes, LENGTH_W'(3), '0);
        region_bytes = '{8'hFF, 8'h5A, 8'h5A};
        send_region();
        region_bytes = '{8'hFF, 8'h5A, 8'h5B};
        send_region();
        wait_idle();

        // zero length acts as one, invalid code in the first position
        configure('0, '0, {16{CODE_INVALID_LAST}}, '0, '0);
        region_bytes = '{8'h7E};
        send_region();
        wait_idle();

        // invalid code past wildcards: short region, then a full window
        dir_codes = '0;
        dir_codes[11:8] = CODE_INVALID_FIRST;
        configure('0, '0, dir_codes, LENGTH_W'(4), '0);
        region_bytes = '{8'h11, 8'h22};
        send_region();
        region_bytes = '{8'h11, 8'h22, 8'h33, 8'h44};
        send_region();
        wait_idle();

        // invalid code behind an exact byte: mismatch hides it, match exposes it
        dir_codes = '0;
        dir_codes[3:0] = CODE_EXACT;
        dir_codes[7:4] = CODE_INVALID_FIRST + 1'b1;
        configure('0, '0, dir_codes, LENGTH_W'(2), '0);
        region_bytes = '{8'h01, 8'h00};
        send_region();
        region_bytes = '{8'h00, 8'h80};
        send_region();
        wait_idle();

        // start offset at its top: nothing is ever tested
        configure({$urandom, $urandom}, {$urandom, $urandom}, '0, LENGTH_W'(1), '1);
        region_bytes = '{8'hAA, 8'h55};
        send_region();
        wait_idle();

        // random phases: receiver mostly stalls, then sender mostly idles, then neither
        first_taken = sb.bytes_taken;
        while (sb.bytes_taken < first_taken + RANDOM_BYTES)
        begin
            if (sb.bytes_taken < first_taken + 550)
            begin
                send_idle_pct = 15;
                recv_stall_pct <= 77;
            end
            else if (sb.bytes_taken < first_taken + 1100)
            begin
                send_idle_pct = 77;
                recv_stall_pct <= 15;
            end
            else
            begin
                send_idle_pct = 0;
                recv_stall_pct <= 0;
                hold_armed <= 1'b1;
            end
            random_phase();
            wait_idle();
            phase_no++;
        end

        wait_idle();
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/mss_pkg.sv
rtl/mss_cfg_regs.sv
rtl/mss_matcher.sv
rtl/masked_signature_scanner.sv
rtl/mss_checker.sv
tb/tb_top.sv
